// File: hdl/sapq_pkg.sv
// Shared types and constants for the sorted-array priority queue.
package sapq_pkg;

  localparam int VALUE_W    = 32;
  localparam int CAP_W      = 7;
  localparam int OCC_W      = 7;
  localparam int STATUS_W   = 2;
  localparam int OUT_DATA_W = 104;  // 103 payload bits padded to whole bytes

  localparam logic [CAP_W-1:0] CAP_RESET = 7'd40;

  // Result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  // Control sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_INS_SCAN,
    S_INS_PUT,
    S_DEL_RD,
    S_DONE
  } state_e;

endpackage

// File: hdl/sorted_array_priority_queue.sv
// Sorted-array priority queue: entries held descending in a one-port-read, one-port-write RAM.
//
// Usage: one operation per input beat on the s_axis channel; tuser selects it
// (0 inserts tdata as a signed 32-bit value, 1 pops the smallest entry). Each
// operation yields exactly one result beat on m_axis with a status in tuser and
// removed value, occupancy, largest and smallest entry in tdata.
// The user writes capacity through cfg_we_i / cfg_wdata_i only while no operation
// is in flight; the block itself does not enforce this. Values above DEPTH act as
// DEPTH, zero refuses every insert.
// After the accept, a refused operation, a pop that empties the queue or an insert
// into an empty queue goes straight to S_DONE; other pops pass S_DEL_RD first, and
// an insert into a non-empty queue walks S_INS_SCAN (then S_INS_PUT if it becomes head).
// The insert's scan is a tail-to-head shift walk through the RAM, one
// entry per cycle, each step reading one entry and writing it one slot down.
// Only one operation is in progress at a time; the next beat is taken the cycle
// after the result has moved into the output register, so a stalled receiver
// blocks new input once one result is parked and the next operation waits in S_DONE.
// Reset empties the queue (count, head and tail to zero) and sets capacity to 40;
// RAM contents are not cleared, since only entries below the count are ever read.
module sorted_array_priority_queue
  import sapq_pkg::*;
#(
  parameter int DEPTH = 64
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // configuration: capacity
  input  logic                   cfg_we_i,
  input  logic [CAP_W-1:0]       cfg_wdata_i,
  // operation input
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [VALUE_W-1:0]     s_axis_tdata,   // [31:0] value
  input  logic                   s_axis_tuser,   // [0] mode
  // result output
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_DATA_W-1:0]  m_axis_tdata,   // [31:0] removed_value, [38:32] occupancy,
                                                 // [70:39] largest, [102:71] smallest, [103] zero
  output logic [STATUS_W-1:0]    m_axis_tuser    // [1:0] status
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam int LW = (CW > CAP_W) ? CW : CAP_W;

  // state and data registers
  state_e              state_q, state_d;
  logic [CW-1:0]       count_q, count_d;
  logic [VALUE_W-1:0]  head_q, head_d;
  logic [VALUE_W-1:0]  tail_q, tail_d;
  logic [AW-1:0]       ptr_q, ptr_d;
  logic [VALUE_W-1:0]  val_q, val_d;
  status_e             status_q, status_d;
  logic [VALUE_W-1:0]  removed_q, removed_d;
  logic [CAP_W-1:0]    cap_q;

  // output register
  logic                m_valid_q;
  logic [OUT_DATA_W-1:0] m_data_q;
  logic [STATUS_W-1:0] m_user_q;
  logic                m_load;

  // RAM ports
  logic [VALUE_W-1:0]  mem [DEPTH];
  logic [VALUE_W-1:0]  rd_data_q;
  logic [AW-1:0]       rd_addr;
  logic                wr_en;
  logic [AW-1:0]       wr_addr;
  logic [VALUE_W-1:0]  wr_data;

  logic                s_accept;
  logic                full;
  logic [LW-1:0]       cnt_ext;

  assign s_axis_tready = (state_q == S_IDLE);
  assign s_accept      = s_axis_tvalid && s_axis_tready;

  // insert refused once count reaches min(capacity, DEPTH)
  assign cnt_ext = LW'(count_q);
  assign full    = (cnt_ext >= LW'(cap_q)) || (cnt_ext >= LW'(DEPTH));

  // entry RAM: one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_q <= mem[rd_addr];
  end

  // capacity register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= CAP_RESET;
    end else if (cfg_we_i) begin
      cap_q <= cfg_wdata_i;
    end
  end

  // control state; head and tail read as zero while empty
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
      head_q  <= '0;
      tail_q  <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      head_q  <= head_d;
      tail_q  <= tail_d;
    end
  end

  // working payload
  always_ff @(posedge clk_i) begin
    ptr_q     <= ptr_d;
    val_q     <= val_d;
    status_q  <= status_d;
    removed_q <= removed_d;
  end

  // sequencer: insert walks from tail toward head, pop refreshes the tail
  always_comb begin
    state_d   = state_q;
    count_d   = count_q;
    head_d    = head_q;
    tail_d    = tail_q;
    ptr_d     = ptr_q;
    val_d     = val_q;
    status_d  = status_q;
    removed_d = removed_q;
    rd_addr   = AW'(count_q - 1'b1);
    wr_en     = 1'b0;
    wr_addr   = ptr_q;
    wr_data   = val_q;
    m_load    = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (s_accept) begin
          val_d     = s_axis_tdata;
          removed_d = '0;
          status_d  = ST_OK;
          state_d   = S_DONE;
          if (!s_axis_tuser) begin
            if (full) begin
              status_d = ST_FULL;
            end else begin
              count_d = count_q + 1'b1;
              if (count_q == '0) begin
                head_d  = s_axis_tdata;
                tail_d  = s_axis_tdata;
                wr_en   = 1'b1;
                wr_addr = '0;
                wr_data = s_axis_tdata;
              end else begin
                if ($signed(s_axis_tdata) > $signed(head_q)) begin
                  head_d = s_axis_tdata;
                end
                if (!($signed(s_axis_tdata) > $signed(tail_q))) begin
                  tail_d = s_axis_tdata;
                end
                ptr_d   = AW'(count_q);
                state_d = S_INS_SCAN;
              end
            end
          end else begin
            if (count_q == '0) begin
              status_d = ST_EMPTY;
            end else begin
              count_d   = count_q - 1'b1;
              removed_d = tail_q;
              if (count_q == CW'(1)) begin
                head_d = '0;
                tail_d = '0;
              end else begin
                rd_addr = AW'(count_q - 1'b1 - 1'b1);
                state_d = S_DEL_RD;
              end
            end
          end
        end
      end
      S_INS_SCAN: begin
        // rd_data_q holds the entry just above the open slot at ptr_q
        wr_en   = 1'b1;
        wr_addr = ptr_q;
        if ($signed(val_q) > $signed(rd_data_q)) begin
          wr_data = rd_data_q;
          ptr_d   = ptr_q - 1'b1;
          if (ptr_q == AW'(1)) begin
            state_d = S_INS_PUT;
          end else begin
            rd_addr = ptr_q - 1'b1 - 1'b1;
          end
        end else begin
          wr_data = val_q;
          state_d = S_DONE;
        end
      end
      S_INS_PUT: begin
        wr_en   = 1'b1;
        wr_addr = ptr_q;
        wr_data = val_q;
        state_d = S_DONE;
      end
      S_DEL_RD: begin
        tail_d  = rd_data_q;
        state_d = S_DONE;
      end
      S_DONE: begin
        if (!m_valid_q || m_axis_tready) begin
          m_load  = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (m_load) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (m_load) begin
      m_data_q <= {1'b0, tail_q, head_q, OCC_W'(count_q), removed_q};
      m_user_q <= status_q;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_user_q;

`ifndef NO_ASSERTIONS
  // occupancy never exceeds the RAM depth
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(DEPTH))
    else $error("count exceeds DEPTH");

  // the shift walk only writes inside the occupied region
  a_scan_addr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_INS_SCAN && wr_en) |-> (CW'(wr_addr) < count_q))
    else $error("shift write beyond occupied region");

  // a result is only loaded from the final sequencer state
  a_load_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_valid_q) |-> $past(state_q) == S_DONE)
    else $error("result loaded outside done state");

  // occupancy changes only on an accepted beat
  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q != $past(count_q)) |-> $past(s_accept))
    else $error("count changed without an accepted beat");
`endif

endmodule
